// ===== src/tpv_pkg.sv =====
`default_nettype none

package tpv_pkg;

  // Default values of the top-level parameters.
  localparam int unsigned MAX_DEPTH_DFLT = 32;
  localparam int unsigned MOVE_BITS_DFLT = 16;

  // Fixed field widths of the transaction ports.
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned PLY_W   = 6;
  localparam int unsigned MOVE_W  = 16;
  localparam int unsigned CFG_W   = 6;
  localparam int unsigned DEPTH_W = 7;

  localparam logic [CFG_W-1:0] CFG_DEPTH_RST = 6'd32;

  // Command queue between the front and the back.
  localparam int unsigned Q_DEPTH = 2;

  // Request codes on the input channel.
  localparam logic [REQ_W-1:0] REQ_SET   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    OP_SET,
    OP_ERR,
    OP_READ,
    OP_CLEAR
  } tpv_op_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [PLY_W-1:0]  ply;
    logic [MOVE_W-1:0] move_code;
  } tpv_in_t;

  typedef struct packed {
    logic [MOVE_W-1:0] move_code_res;
    logic              status;
    logic              last;
  } tpv_out_t;

  typedef struct packed {
    tpv_op_t            op;
    logic [PLY_W-1:0]   ply;
    logic [MOVE_W-1:0]  move;
    logic [DEPTH_W-1:0] depth;
  } tpv_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tpv_qstat_t;

endpackage

`default_nettype wire

// ===== src/tpv_front.sv =====
`default_nettype none

module tpv_front import tpv_pkg::*; #(
  parameter int unsigned MAX_DEPTH = MAX_DEPTH_DFLT
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output      logic             busy,
  input  wire tpv_in_t          in_item,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  input  wire tpv_qstat_t       q_stat,
  input  wire logic             init_busy,
  output      logic             q_push,
  output      tpv_cmd_t         q_cmd
);

  localparam logic [DEPTH_W-1:0] DMAX = DEPTH_W'(MAX_DEPTH);

  logic [CFG_W-1:0]   depth_r;
  logic [DEPTH_W-1:0] eff_depth;
  logic               accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= CFG_DEPTH_RST;
    end else if (cfg_we) begin
      depth_r <= cfg_wdata;
    end
  end

  // The register value is saturated to the range 1..MAX_DEPTH.
  always_comb begin
    eff_depth = {1'b0, depth_r};
    if (depth_r == '0) begin
      eff_depth = DEPTH_W'(1);
    end else if ({1'b0, depth_r} > DMAX) begin
      eff_depth = DMAX;
    end
  end

  assign busy   = q_stat.full | init_busy;
  assign accept = start & ~busy;

  always_comb begin
    q_push      = 1'b0;
    q_cmd.op    = OP_SET;
    q_cmd.ply   = in_item.ply;
    q_cmd.move  = in_item.move_code;
    q_cmd.depth = eff_depth;
    unique case (in_item.req_type)
      REQ_SET: begin
        q_push   = accept;
        q_cmd.op = ({1'b0, in_item.ply} >= eff_depth) ? OP_ERR : OP_SET;
      end
      REQ_READ: begin
        q_push   = accept;
        q_cmd.op = OP_READ;
      end
      REQ_CLEAR: begin
        q_push   = accept;
        q_cmd.op = OP_CLEAR;
      end
      // The unused request code is taken and dropped without a result.
      default: q_push = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/tpv_cmd_fifo.sv =====
`default_nettype none

module tpv_cmd_fifo import tpv_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire tpv_cmd_t   push_cmd,
  input  wire logic       pop,
  output      tpv_cmd_t   head_cmd,
  output      tpv_qstat_t stat
);

  localparam int unsigned QP_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned QC_W = $clog2(Q_DEPTH + 1);

  tpv_cmd_t        slots_r [Q_DEPTH];
  logic [QP_W-1:0] wptr_r, wptr_nxt;
  logic [QP_W-1:0] rptr_r, rptr_nxt;
  logic [QC_W-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  assign stat.full  = (count_r == QC_W'(Q_DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push & ~stat.full;
  assign do_pop     = pop & ~stat.empty;
  assign head_cmd   = slots_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == QP_W'(Q_DEPTH - 1)) ? '0 : QP_W'(wptr_r + 1'b1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == QP_W'(Q_DEPTH - 1)) ? '0 : QP_W'(rptr_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      count_nxt = QC_W'(count_r + 1'b1);
    end else if (do_pop && !do_push) begin
      count_nxt = QC_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wptr_r] <= push_cmd;
    end
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/tpv_back.sv =====
`default_nettype none

module tpv_back import tpv_pkg::*; #(
  parameter int unsigned MAX_DEPTH = MAX_DEPTH_DFLT,
  parameter int unsigned MOVE_BITS = MOVE_BITS_DFLT
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire tpv_cmd_t   q_cmd,
  input  wire tpv_qstat_t q_stat,
  output      logic       q_pop,
  output      logic       init_busy,
  output      logic       out_strobe,
  output      tpv_out_t   out_item
);

  localparam int unsigned IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int unsigned DEP_W = $clog2(MAX_DEPTH + 1);
  localparam int unsigned AW    = 2 * IDX_W;
  localparam int unsigned MW    = (MOVE_BITS < MOVE_W) ? MOVE_BITS : MOVE_W;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_COPY,
    S_READ,
    S_CLR
  } state_t;

  state_t           state_r, state_nxt;
  tpv_cmd_t         cmd_r, cmd_nxt;
  logic [DEP_W-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0]    clr_addr_r, clr_addr_nxt;
  logic             rv_r, rv_nxt;
  logic [IDX_W-1:0] rv_k_r, rv_k_nxt;
  logic             rv_last_r, rv_last_nxt;
  logic             strobe_r, strobe_nxt;
  tpv_out_t         out_r, out_nxt;

  // Row p, entry k lives at address {p, k}.
  logic [MW-1:0]    pv_mem_r [2**AW];
  logic [MW-1:0]    rdata_r;
  logic             we, re;
  logic [AW-1:0]    waddr, raddr;
  logic [MW-1:0]    wdata;

  logic [DEP_W-1:0] depth;
  logic [IDX_W-1:0] ply;
  logic [DEP_W-1:0] copy_len;
  logic [MOVE_W-1:0] rdata_ext;

  assign depth    = cmd_r.depth[DEP_W-1:0];
  assign ply      = cmd_r.ply[IDX_W-1:0];
  assign copy_len = DEP_W'(depth - DEP_W'(ply) - 1'b1);

  always_comb begin
    rdata_ext         = '0;
    rdata_ext[MW-1:0] = rdata_r;
  end

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    cnt_nxt      = cnt_r;
    clr_addr_nxt = clr_addr_r;
    rv_nxt       = 1'b0;
    rv_k_nxt     = rv_k_r;
    rv_last_nxt  = rv_last_r;
    strobe_nxt   = 1'b0;
    out_nxt      = '0;
    q_pop        = 1'b0;
    we           = 1'b0;
    waddr        = '0;
    wdata        = '0;
    re           = 1'b0;
    raddr        = '0;

    unique case (state_r)
      S_INIT, S_CLR: begin
        we           = 1'b1;
        waddr        = clr_addr_r;
        clr_addr_nxt = AW'(clr_addr_r + 1'b1);
        if (clr_addr_r == '1) begin
          state_nxt = S_IDLE;
          // Only a clear request reports; the pass after reset is silent.
          if (state_r == S_CLR) begin
            strobe_nxt   = 1'b1;
            out_nxt.last = 1'b1;
          end
        end
      end

      S_IDLE: begin
        if (!q_stat.empty) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          unique case (q_cmd.op)
            OP_ERR: begin
              strobe_nxt     = 1'b1;
              out_nxt.status = 1'b1;
              out_nxt.last   = 1'b1;
            end
            OP_SET: begin
              we    = 1'b1;
              waddr = {q_cmd.ply[IDX_W-1:0], {IDX_W{1'b0}}};
              wdata = q_cmd.move[MW-1:0];
              if (DEPTH_W'({1'b0, q_cmd.ply} + 1'b1) < q_cmd.depth) begin
                state_nxt = S_COPY;
                cnt_nxt   = '0;
              end else begin
                strobe_nxt   = 1'b1;
                out_nxt.last = 1'b1;
              end
            end
            OP_READ: begin
              state_nxt = S_READ;
              cnt_nxt   = '0;
            end
            OP_CLEAR: begin
              state_nxt    = S_CLR;
              clr_addr_nxt = '0;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      // Row ply+1 is read one entry a cycle and written one place further
      // along row ply as the read data returns.
      S_COPY: begin
        if (cnt_r != copy_len) begin
          re       = 1'b1;
          raddr    = {IDX_W'(ply + 1'b1), cnt_r[IDX_W-1:0]};
          cnt_nxt  = DEP_W'(cnt_r + 1'b1);
          rv_nxt   = 1'b1;
          rv_k_nxt = cnt_r[IDX_W-1:0];
        end
        if (rv_r) begin
          we    = 1'b1;
          waddr = {ply, IDX_W'(rv_k_r + 1'b1)};
          wdata = rdata_r;
        end
        if (cnt_r == copy_len && !rv_r) begin
          state_nxt    = S_IDLE;
          strobe_nxt   = 1'b1;
          out_nxt.last = 1'b1;
        end
      end

      S_READ: begin
        if (cnt_r != depth) begin
          re          = 1'b1;
          raddr       = {{IDX_W{1'b0}}, cnt_r[IDX_W-1:0]};
          cnt_nxt     = DEP_W'(cnt_r + 1'b1);
          rv_nxt      = 1'b1;
          rv_last_nxt = (DEP_W'(cnt_r + 1'b1) == depth);
        end
        if (rv_r) begin
          strobe_nxt            = 1'b1;
          out_nxt.move_code_res = rdata_ext;
          out_nxt.last          = rv_last_r;
        end
        if (cnt_r == depth && !rv_r) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      pv_mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= pv_mem_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    rv_k_r    <= rv_k_nxt;
    rv_last_r <= rv_last_nxt;
    out_r     <= out_nxt;
    if (!rst_n) begin
      state_r    <= S_INIT;
      cnt_r      <= '0;
      clr_addr_r <= '0;
      rv_r       <= 1'b0;
      strobe_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      clr_addr_r <= clr_addr_nxt;
      rv_r       <= rv_nxt;
      strobe_r   <= strobe_nxt;
    end
  end

  assign init_busy  = (state_r == S_INIT);
  assign out_strobe = strobe_r;
  assign out_item   = out_r;

endmodule

`default_nettype wire

// ===== src/triangular_pv_table.sv =====
// Triangular principal-variation table.
//
// Input channel: a transaction is taken at a clock edge where start is high
// and busy is low. in_item carries req_type (0 set, 1 read, 2 clear), ply and
// move_code. Code 3 is taken and produces nothing.
// Configuration: cfg_we writes cfg_wdata into the depth register D, which is
// saturated to 1..MAX_DEPTH. Write it only while the block is idle and clear
// the table after changing it.
// Result channel: each result is shown on out_item for one cycle with
// out_strobe high. The receiver cannot stall; results are never held.
// The table memory in the back end has one read port and one write port. A set
// with ply below D-1 writes its move and then copies row ply+1 one place along
// into row ply, one entry a cycle; a read gives its D results on consecutive
// cycles; a clear writes every word of the table memory, one word a cycle.
// A two-entry command queue lets up to two transactions wait behind the
// running one; busy rises when it is full.
// Reset: the depth register returns to 32 and a clearing pass of the same
// length as a clear runs with busy high and no result.

`default_nettype none

module triangular_pv_table import tpv_pkg::*; #(
  parameter int unsigned MAX_DEPTH = MAX_DEPTH_DFLT,
  parameter int unsigned MOVE_BITS = MOVE_BITS_DFLT
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output      logic             busy,
  input  wire tpv_in_t          in_item,
  output      logic             out_strobe,
  output      tpv_out_t         out_item,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  tpv_qstat_t q_stat;
  tpv_cmd_t   push_cmd;
  tpv_cmd_t   head_cmd;
  logic       q_push;
  logic       q_pop;
  logic       init_busy;

  tpv_front #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_stat    (q_stat),
    .init_busy (init_busy),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  tpv_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .stat     (q_stat)
  );

  tpv_back #(
    .MAX_DEPTH (MAX_DEPTH),
    .MOVE_BITS (MOVE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_cmd      (head_cmd),
    .q_stat     (q_stat),
    .q_pop      (q_pop),
    .init_busy  (init_busy),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

`default_nettype wire

// ===== src/tpv_checker.sv =====
`default_nettype none

module tpv_checker import tpv_pkg::*; (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     busy,
  input wire logic     out_strobe,
  input wire tpv_out_t out_item
);

  // The clearing pass after reset keeps the input side closed.
  a_busy_after_reset: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");

  a_quiet_after_reset: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("result strobe right after reset");

  // An out-of-range set gives a single empty result.
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.status |-> out_item.last && out_item.move_code_res == '0)
    else $error("error result is not a single empty transaction");

  // Only a read gives more than one result, and they come without gaps.
  a_read_stream: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_item.last |=> out_strobe)
    else $error("gap inside a read run");

  a_read_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_item.last |-> !out_item.status)
    else $error("error status inside a read run");

endmodule

bind triangular_pv_table tpv_checker u_tpv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);

`default_nettype wire
